FILE: design/rafp_pkg.sv
// Shared types and constants for the radar altimeter frame parser.
// No dependencies; used by rafp_parser and radar_altimeter_frame_parser.
package rafp_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'hFE;
	localparam logic [7:0] VERSION_BYTE = 8'h01;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_NO_SYNC  = 2'd2,
		ST_VERSION  = 2'd3
	} status_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [15:0] altitude_cm;
		logic [7:0]  signal_to_noise;
	} result_t;

endpackage

FILE: design/radar_altimeter_frame_parser.sv
// Top level of the radar altimeter frame parser: input register, parser, result register.
// Depends on rafp_pkg and rafp_parser.
//
// Accepts one serial byte per transaction and reports framing results: a six-byte frame
// (sync 0xFE, version 0x01, altitude low, altitude high, SNR, checksum) gives one result
// with status good or checksum mismatch, a bad version byte or a non-sync byte right after
// a frame gives an error result with zero altitude and SNR, and bytes seen while hunting
// for sync give nothing. A byte is taken every cycle while the output side keeps up; its
// result, if any, passes through the input register and then the result register, with the
// parse logic combinational between them.
module radar_altimeter_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] altitude_cm,
	output logic [7:0]  signal_to_noise
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [15:0]       altitude_q;
	logic [7:0]        snr_q;
	logic              out_free;
	logic              advance;
	rafp_pkg::result_t res;

	// The result register can load when empty or when its transaction completes now.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	rafp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (advance),
		.rx_byte (rx_byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= advance && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
		if (advance && res.valid) begin
			status_q   <= res.status;
			altitude_q <= res.altitude_cm;
			snr_q      <= res.signal_to_noise;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign altitude_cm     = altitude_q;
	assign signal_to_noise = snr_q;

endmodule

FILE: design/rafp_parser.sv
// Frame phase tracking, byte capture and checksum check for one byte per cycle while byte_en is high.
// Depends on rafp_pkg for the sync and version constants and the result type.
module rafp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic [7:0]          rx_byte,
	output rafp_pkg::result_t   res
);

	typedef enum logic [2:0] {
		PH_HUNT        = 3'd0,
		PH_VERSION     = 3'd1,
		PH_ALT_LO      = 3'd2,
		PH_ALT_HI      = 3'd3,
		PH_SNR         = 3'd4,
		PH_CHECKSUM    = 3'd5,
		PH_AFTER_FRAME = 3'd6
	} phase_t;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [7:0]  alt_lo_q;
	logic [7:0]  alt_hi_q;
	logic [7:0]  snr_q;
	logic [7:0]  sum;

	// Version byte is fixed, so it enters the checksum as a constant.
	assign sum = rafp_pkg::VERSION_BYTE + alt_lo_q + alt_hi_q + snr_q;

	always_comb begin
		phase_d             = phase_q;
		res.valid           = 1'b0;
		res.status          = rafp_pkg::ST_GOOD;
		res.altitude_cm     = 16'd0;
		res.signal_to_noise = 8'd0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == rafp_pkg::SYNC_BYTE) begin
					phase_d = PH_VERSION;
				end
			end
			PH_AFTER_FRAME: begin
				if (rx_byte == rafp_pkg::SYNC_BYTE) begin
					phase_d = PH_VERSION;
				end else begin
					phase_d    = PH_HUNT;
					res.valid  = 1'b1;
					res.status = rafp_pkg::ST_NO_SYNC;
				end
			end
			PH_VERSION: begin
				if (rx_byte == rafp_pkg::VERSION_BYTE) begin
					phase_d = PH_ALT_LO;
				end else begin
					phase_d    = PH_HUNT;
					res.valid  = 1'b1;
					res.status = rafp_pkg::ST_VERSION;
				end
			end
			PH_ALT_LO:  phase_d = PH_ALT_HI;
			PH_ALT_HI:  phase_d = PH_SNR;
			PH_SNR:     phase_d = PH_CHECKSUM;
			PH_CHECKSUM: begin
				phase_d             = PH_AFTER_FRAME;
				res.valid           = 1'b1;
				res.status          = (sum == rx_byte) ? rafp_pkg::ST_GOOD
				                                       : rafp_pkg::ST_CHECKSUM;
				res.altitude_cm     = {alt_hi_q, alt_lo_q};
				res.signal_to_noise = snr_q;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			alt_lo_q <= 8'd0;
			alt_hi_q <= 8'd0;
			snr_q    <= 8'd0;
		end else if (byte_en) begin
			phase_q <= phase_d;
			if (phase_q == PH_ALT_LO) begin
				alt_lo_q <= rx_byte;
			end
			if (phase_q == PH_ALT_HI) begin
				alt_hi_q <= rx_byte;
			end
			if (phase_q == PH_SNR) begin
				snr_q <= rx_byte;
			end
		end
	end

endmodule
